[rtl/core/rde_pkg.sv]
// shared types, codes and sizes for the reversible deque engine
package rde_pkg;

  // sizes
  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int VALUE_W   = 16;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = ((VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_W + CNT_W + 7) / 8) * 8;

  // operation codes
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_CLEAR  = 3'd0;
  localparam op_t OP_APPEND = 3'd1;
  localparam op_t OP_TOGGLE = 3'd2;
  localparam op_t OP_DELETE = 3'd3;
  localparam op_t OP_READ   = 3'd4;

  // result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ERROR = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transfer: apply the operation
    logic capture;  // load popped element into the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_hit; // pending operation is a read out on a non-empty deque with no sticky error
  } dp_stat_t;

endpackage

[rtl/core/rde_datapath.sv]
// deque state, element memory and result registers
module rde_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  rde_pkg::dp_cmd_t                cmd,
  output rde_pkg::dp_stat_t               stat,
  input  rde_pkg::op_t                    operation,
  input  logic [rde_pkg::VALUE_W-1:0]     value,
  output logic [rde_pkg::VALUE_W-1:0]     res_data,
  output rde_pkg::status_t                res_status,
  output logic                            res_last,
  output logic [rde_pkg::CNT_W-1:0]       res_occupancy
);
  import rde_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;

  logic [ADDR_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              reversed, reversed_next;
  logic              error, error_next;

  status_t           status_c;
  logic              last_c;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] tail_addr, back_addr, front_addr;
  logic              is_empty, is_full;

  // ring addresses
  assign tail_addr  = head + count[ADDR_W-1:0];
  assign back_addr  = tail_addr - ADDR_W'(1);
  assign front_addr = reversed ? back_addr : head;
  assign is_empty   = (count == '0);
  assign is_full    = (count == CNT_W'(DEPTH));

  assign stat.read_hit = !error && (operation == OP_READ) && !is_empty;

  // next state of the deque for the offered operation
  always_comb begin
    head_next     = head;
    count_next    = count;
    reversed_next = reversed;
    error_next    = error;
    status_c      = ST_OK;
    last_c        = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    if (operation == OP_CLEAR) begin
      head_next     = '0;
      count_next    = '0;
      reversed_next = 1'b0;
      error_next    = 1'b0;
    end else if (error) begin
      status_c = ST_ERROR;
    end else begin
      case (operation)
        OP_APPEND: begin
          if (is_full) begin
            status_c = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        OP_TOGGLE: begin
          reversed_next = !reversed;
        end
        OP_DELETE: begin
          if (is_empty) begin
            error_next = 1'b1;
            status_c   = ST_ERROR;
          end else begin
            count_next = count - CNT_W'(1);
            if (!reversed) head_next = head + ADDR_W'(1);
          end
        end
        OP_READ: begin
          if (is_empty) begin
            status_c = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            count_next = count - CNT_W'(1);
            last_c     = (count == CNT_W'(1));
            if (!reversed) head_next = head + ADDR_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // deque control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
      error    <= 1'b0;
    end else if (cmd.accept) begin
      head     <= head_next;
      count    <= count_next;
      reversed <= reversed_next;
      error    <= error_next;
    end
  end

  // element memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[tail_addr] <= value;
    end
    if (cmd.accept && rd_en) begin
      rdata <= mem[front_addr];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_data      <= '0;
      res_status    <= status_c;
      res_last      <= last_c;
      res_occupancy <= count_next;
    end else if (cmd.capture) begin
      res_data <= rdata;
    end
  end

endmodule

[rtl/core/rde_ctrl.sv]
// handshake controller: accepts operations and sequences memory reads
module rde_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rde_pkg::dp_stat_t  stat,
  output rde_pkg::dp_cmd_t   cmd
);
  import rde_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  state_t state, state_next;
  logic   valid, valid_next;

  assign out_valid   = valid;
  assign in_ready    = (state == S_IDLE) && (!valid || out_ready);
  assign cmd.accept  = in_valid && in_ready;
  assign cmd.capture = (state == S_FETCH);

  // next state and result valid
  always_comb begin
    state_next = state;
    valid_next = valid;
    case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          if (stat.read_hit) begin
            state_next = S_FETCH;
            valid_next = 1'b0;
          end else begin
            valid_next = 1'b1;
          end
        end else if (out_ready) begin
          valid_next = 1'b0;
        end
      end
      S_FETCH: begin
        state_next = S_IDLE;
        valid_next = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
        valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

endmodule

[rtl/core/reversible_deque_engine_top.sv]
// top level of the reversible deque engine
// results: registered on the input transfer; a read out that pops an element
//   is first read into the element memory's output register, then captured
// throughput: one operation per cycle; a read out that pops an element holds
//   off the next input transfer while it is fetched, as does an untaken result
// reset: synchronous rst clears the deque (empty, forward, no error)
module reversible_deque_engine_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rde_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // value
  input  logic [rde_pkg::OP_W-1:0]           s_axis_tuser,  // operation
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rde_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // data, occupancy
  output logic [rde_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
  output logic                               m_axis_tlast
);
  import rde_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [VALUE_W-1:0] res_data;
  status_t           res_status;
  logic [CNT_W-1:0]  res_occupancy;

  rde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rde_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (s_axis_tuser),
    .value         (s_axis_tdata[VALUE_W-1:0]),
    .res_data      (res_data),
    .res_status    (res_status),
    .res_last      (m_axis_tlast),
    .res_occupancy (res_occupancy)
  );

  // output packing
  assign m_axis_tdata = {{(OUT_DATA_W - VALUE_W - CNT_W){1'b0}}, res_occupancy, res_data};
  assign m_axis_tuser = res_status;

  // an input transfer never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input transfer while result pending");

  // a popping read out is followed by the memory capture
  a_read_capture: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && stat.read_hit) |=> (cmd.capture && !m_axis_tvalid))
    else $error("read out not followed by capture");

  // capture always presents a result next cycle
  a_capture_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> m_axis_tvalid)
    else $error("captured result not presented");

  // last only on a successful read that emptied the deque
  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> ((m_axis_tuser == ST_OK) && (res_occupancy == '0)))
    else $error("last with nonzero occupancy or bad status");

endmodule

[test/reversible_deque_engine_top_tb.sv]
// self-checking testbench for the reversible deque engine top level
module reversible_deque_engine_top_tb;
  import rde_pkg::*;

  // codes outside the defined operation set
  localparam op_t OP_SPARE_LO = OP_READ + 1;
  localparam op_t OP_SPARE_HI = '1;

  // window of accepted operations during which neither side idles
  localparam int QUIET_FROM = 600;
  localparam int QUIET_TO   = 900;
  localparam int IDLE_PCT   = 17;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } deque_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    status_t            status;
    logic               last;
    logic [CNT_W-1:0]   occupancy;
  } deque_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  reversible_deque_engine_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // operations waiting to be sent and results waiting to arrive
  deque_op_t     op_backlog[$];
  deque_result_t pending_results[$];

  int in_count = 0;
  int n_items = 0;
  int errors = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_sticky = 0;
  int n_empty_reads = 0;
  int n_pops = 0;

  logic idling_allowed;
  assign idling_allowed = (in_count < QUIET_FROM) || (in_count >= QUIET_TO);

  // mirror of the deque state
  logic [VALUE_W-1:0] ring_mirror [DEPTH];
  logic [ADDR_W-1:0]  mirror_head = '0;
  logic [CNT_W-1:0]   mirror_count = '0;
  logic               mirror_rev = 1'b0;
  logic               mirror_err = 1'b0;

  // rough occupancy and error tracking used only to shape the stimulus
  int  plan_count = 0;
  bit  plan_err = 0;

  // apply one operation to the mirror and work out its result
  task automatic apply_deque_op(input op_t op, input logic [VALUE_W-1:0] val,
                                output deque_result_t res);
    logic [ADDR_W-1:0] slot;
    res = '0;
    res.status = ST_OK;
    if (op == OP_CLEAR) begin
      mirror_head = '0;
      mirror_count = '0;
      mirror_rev = 1'b0;
      mirror_err = 1'b0;
    end else if (mirror_err) begin
      res.status = ST_ERROR;
    end else begin
      case (op)
        OP_APPEND: begin
          if (mirror_count >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            slot = mirror_head + mirror_count[ADDR_W-1:0];
            ring_mirror[slot] = val;
            mirror_count = mirror_count + CNT_W'(1);
          end
        end
        OP_TOGGLE: begin
          mirror_rev = !mirror_rev;
        end
        OP_DELETE: begin
          if (mirror_count == 0) begin
            mirror_err = 1'b1;
            res.status = ST_ERROR;
          end else begin
            if (!mirror_rev) mirror_head = mirror_head + ADDR_W'(1);
            mirror_count = mirror_count - CNT_W'(1);
          end
        end
        OP_READ: begin
          if (mirror_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            // logical front is the physical back while reversed
            slot = mirror_rev ? mirror_head + ADDR_W'(mirror_count - CNT_W'(1)) : mirror_head;
            res.data = ring_mirror[slot];
            if (!mirror_rev) mirror_head = mirror_head + ADDR_W'(1);
            mirror_count = mirror_count - CNT_W'(1);
            res.last = (mirror_count == 0);
          end
        end
        default: begin
        end
      endcase
    end
    res.occupancy = mirror_count;
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  // queue one operation, tracking occupancy for stimulus shaping
  task automatic plan_op(input op_t op, input logic [VALUE_W-1:0] val);
    deque_op_t item;
    item.op = op;
    item.value = val;
    op_backlog.insert(op_backlog.size(), item);
    if (op == OP_CLEAR) begin
      plan_count = 0;
      plan_err = 0;
    end else if (!plan_err) begin
      case (op)
        OP_APPEND: if (plan_count < DEPTH) plan_count++;
        OP_DELETE: if (plan_count == 0) plan_err = 1; else plan_count--;
        OP_READ:   if (plan_count > 0) plan_count--;
        default: begin
        end
      endcase
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'($urandom);
  endfunction

  // driver: next operation or an idle cycle whenever the slot is free
  always @(posedge clk) begin
    deque_op_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (op_backlog.size() > 0 &&
          !(idling_allowed && $urandom_range(99) < IDLE_PCT)) begin
        item = op_backlog[0];
        op_backlog.delete(0);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(item.value);
        s_axis_tuser  <= item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check result transfers, then predict from input transfers
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idling_allowed && $urandom_range(99) < IDLE_PCT);
      if (m_axis_tvalid && m_axis_tready) begin
        got.data      = m_axis_tdata[VALUE_W-1:0];
        got.occupancy = m_axis_tdata[VALUE_W +: CNT_W];
        got.status    = m_axis_tuser;
        got.last      = m_axis_tlast;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got data %0h status %0d %s",
                   $time, got.data, got.status,
                   $sformatf("last %0b occ %0d", got.last, got.occupancy));
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          n_checked++;
          check_field("data", want.data, got.data);
          check_field("status", want.status, got.status);
          check_field("last", want.last, got.last);
          check_field("occupancy", want.occupancy, got.occupancy);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_deque_op(s_axis_tuser, s_axis_tdata[VALUE_W-1:0], want);
        pending_results.insert(pending_results.size(), want);
        in_count <= in_count + 1;
        case (want.status)
          ST_FULL:  n_full++;
          ST_ERROR: n_sticky++;
          ST_EMPTY: n_empty_reads++;
          default:  if (s_axis_tuser == OP_READ) n_pops++;
        endcase
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    int k;

    // directed: empty read, ends of the value range, reversal, sticky error,
    // spare codes with and without the error, clear under error
    plan_op(OP_CLEAR, 16'hFFFF);
    plan_op(OP_READ, '0);
    plan_op(OP_APPEND, '0);
    plan_op(OP_APPEND, '1);
    plan_op(OP_APPEND, 16'h5555);
    plan_op(OP_TOGGLE, 16'hFFFF);
    plan_op(OP_READ, '0);
    plan_op(OP_TOGGLE, '0);
    plan_op(OP_READ, 16'hFFFF);
    plan_op(OP_READ, '0);
    plan_op(OP_READ, '0);
    plan_op(OP_SPARE_LO, 16'h1234);
    plan_op(OP_SPARE_HI, '1);
    plan_op(OP_APPEND, 16'hAAAA);
    plan_op(OP_TOGGLE, '0);
    plan_op(OP_DELETE, 16'hFFFF);
    plan_op(OP_TOGGLE, '0);
    plan_op(OP_DELETE, '0);
    plan_op(OP_APPEND, 16'h00FF);
    plan_op(OP_TOGGLE, '0);
    plan_op(OP_READ, '0);
    plan_op(OP_DELETE, '0);
    plan_op(OP_SPARE_LO + 1'b1, '0);
    plan_op(OP_CLEAR, '0);
    plan_op(OP_APPEND, 16'h8001);
    plan_op(OP_READ, 16'h7FFE);

    // random mix around small occupancy, with errors as noise
    for (k = 0; k < 250; k++) begin
      r = $urandom_range(99);
      if (plan_err && r < 40)  plan_op(OP_CLEAR, rand_value());
      else if (r < 40)         plan_op(OP_APPEND, rand_value());
      else if (r < 62)         plan_op(OP_READ, rand_value());
      else if (r < 72)         plan_op(OP_TOGGLE, rand_value());
      else if (r < 81)         plan_op(OP_DELETE, rand_value());
      else if (r < 85)         plan_op(OP_CLEAR, rand_value());
      else if (r < 91)         plan_op(op_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
                                       rand_value());
      else                     plan_op(OP_APPEND, rand_value());
    end

    // fill to capacity with a little churn, then push against full
    plan_op(OP_CLEAR, rand_value());
    while (plan_count < DEPTH) begin
      r = $urandom_range(99);
      if (r < 92)      plan_op(OP_APPEND, rand_value());
      else if (r < 96) plan_op(OP_TOGGLE, rand_value());
      else             plan_op(OP_READ, rand_value());
    end
    plan_op(OP_APPEND, rand_value());
    plan_op(OP_APPEND, rand_value());
    plan_op(OP_TOGGLE, rand_value());
    plan_op(OP_APPEND, rand_value());
    plan_op(OP_DELETE, rand_value());
    plan_op(OP_APPEND, rand_value());
    plan_op(OP_APPEND, rand_value());
    plan_op(OP_READ, rand_value());

    // drain from either end with occasional refills
    for (k = 0; k < 300; k++) begin
      r = $urandom_range(99);
      if (r < 70)      plan_op(OP_READ, rand_value());
      else if (r < 80) plan_op(OP_TOGGLE, rand_value());
      else if (r < 90) plan_op(OP_DELETE, rand_value());
      else             plan_op(OP_APPEND, rand_value());
    end
    plan_op(OP_CLEAR, rand_value());
    plan_op(OP_APPEND, rand_value());
    plan_op(OP_READ, rand_value());
    n_items = op_backlog.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (in_count < n_items) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("%0d operations sent, %0d results checked, %0d mismatches", in_count,
             n_checked, errors);
    $display("covered %0d pops, %0d empty reads, %0d full refusals, %0d sticky-error answers",
             n_pops, n_empty_reads, n_full, n_sticky);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[reversible_deque_engine_top.f]
rtl/core/rde_pkg.sv
rtl/core/rde_datapath.sv
rtl/core/rde_ctrl.sv
rtl/core/reversible_deque_engine_top.sv
test/reversible_deque_engine_top_tb.sv
